// ===== sv/bc13_pkg.sv =====
// Shared types for the BC1/BC3 texture block decoder.
`default_nettype none

package bc13_pkg;

  // One compressed 4x4 block
  typedef struct packed {
    logic [63:0] color_block;
    logic [63:0] alpha_block;
  } in_t;

  // One decoded row of the block
  typedef struct packed {
    logic [31:0] pixel_col0;
    logic [31:0] pixel_col1;
    logic [31:0] pixel_col2;
    logic [31:0] pixel_col3;
    logic [1:0]  row_number;
    logic        last_row;
  } out_t;

  // Palettes and per-pixel indices of one block
  typedef struct packed {
    logic [3:0][23:0]  cpal;   // {B, G, R}
    logic [7:0][7:0]   apal;
    logic [15:0][1:0]  cidx;
    logic [15:0][2:0]  aidx;
  } pal_t;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

endpackage

`default_nettype wire

// ===== sv/bc13_palette.sv =====
// Builds the colour and alpha palettes of one block.
`default_nettype none

module bc13_palette (
  input  bc13_pkg::in_t  blk_i,
  input  logic           bc3_i,
  output bc13_pkg::pal_t pal_o
);

  // Truncating divides by reciprocal multiply, exact over the ranges used here
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [19:0] p;
    p = {10'd0, x} * 20'd683;
    return p[18:11];
  endfunction

  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [21:0] p;
    p = {11'd0, x} * 22'd1639;
    return p[20:13];
  endfunction

  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [21:0] p;
    p = {11'd0, x} * 22'd2341;
    return p[21:14];
  endfunction

  function automatic logic [23:0] widen(input logic [15:0] c);
    logic [7:0] r, g, b;
    r = {c[15:11], c[15:13]};
    g = {c[10:5], c[10:9]};
    b = {c[4:0], c[4:2]};
    return {b, g, r};
  endfunction

  // (2*x + y) / 3 per channel
  function automatic logic [23:0] blend3(input logic [23:0] x, input logic [23:0] y);
    logic [23:0] res;
    for (int ch = 0; ch < 3; ch++) begin
      res[ch*8 +: 8] = div3({1'b0, x[ch*8 +: 8], 1'b0} + {2'b0, y[ch*8 +: 8]});
    end
    return res;
  endfunction

  function automatic logic [23:0] mid(input logic [23:0] x, input logic [23:0] y);
    logic [23:0] res;
    logic [8:0]  s;
    for (int ch = 0; ch < 3; ch++) begin
      s = {1'b0, x[ch*8 +: 8]} + {1'b0, y[ch*8 +: 8]};
      res[ch*8 +: 8] = s[8:1];
    end
    return res;
  endfunction

  logic [15:0] c0, c1;
  logic [23:0] e0, e1;
  logic [7:0]  a0, a1;
  logic [10:0] s;

  assign c0 = blk_i.color_block[15:0];
  assign c1 = blk_i.color_block[31:16];
  assign e0 = widen(c0);
  assign e1 = widen(c1);
  assign a0 = blk_i.alpha_block[7:0];
  assign a1 = blk_i.alpha_block[15:8];

  always_comb begin
    pal_o.cidx    = blk_i.color_block[63:32];
    pal_o.aidx    = blk_i.alpha_block[63:16];
    pal_o.cpal[0] = e0;
    pal_o.cpal[1] = e1;
    if (c0 > c1) begin
      pal_o.cpal[2] = blend3(e0, e1);
      pal_o.cpal[3] = blend3(e1, e0);
    end else begin
      pal_o.cpal[2] = mid(e0, e1);
      pal_o.cpal[3] = '0;
    end

    s = '0;
    for (int k = 0; k < 8; k++) begin
      pal_o.apal[k] = bc13_pkg::ALPHA_OPAQUE;
    end
    if (bc3_i) begin
      pal_o.apal[0] = a0;
      pal_o.apal[1] = a1;
      if (a0 > a1) begin
        for (int k = 1; k <= 6; k++) begin
          s = 11'(7 - k) * {3'd0, a0} + 11'(k) * {3'd0, a1};
          pal_o.apal[k+1] = div7(s);
        end
      end else begin
        for (int k = 1; k <= 4; k++) begin
          s = 11'(5 - k) * {3'd0, a0} + 11'(k) * {3'd0, a1};
          pal_o.apal[k+1] = div5(s);
        end
        pal_o.apal[6] = 8'd0;
        pal_o.apal[7] = bc13_pkg::ALPHA_OPAQUE;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/bc13_row_mux.sv =====
// Looks up the four pixels of one row from the block palettes.
`default_nettype none

module bc13_row_mux (
  input  bc13_pkg::pal_t pal_i,
  input  logic [1:0]     row_i,
  output bc13_pkg::out_t row_o
);

  logic [3:0][31:0] px;

  always_comb begin
    for (int col = 0; col < 4; col++) begin
      px[col] = {pal_i.apal[pal_i.aidx[{row_i, 2'(col)}]],
                 pal_i.cpal[pal_i.cidx[{row_i, 2'(col)}]]};
    end
    row_o.pixel_col0 = px[0];
    row_o.pixel_col1 = px[1];
    row_o.pixel_col2 = px[2];
    row_o.pixel_col3 = px[3];
    row_o.row_number = row_i;
    row_o.last_row   = (row_i == 2'd3);
  end

endmodule

`default_nettype wire

// ===== sv/bc1_bc3_texture_block_decoder_top.sv =====
// Top level of the BC1/BC3 texture block decoder.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------
//   block in | start / busy       | item_i  (color, alpha block)
//   rows out | res_strobe_o       | res_o   (4 pixels, row info)
//   config   | cfg_we_i           | cfg_wdata_i (format_mode)
//
// The result port emits one row per cycle, and a new block can be accepted
// while the previous one is still emitting rows. Row 0 is registered in in_q,
// then pal_q, then res_q; rows 1..3 follow in consecutive cycles. busy is high
// while a block waits behind one that has not reached its last row.
// Reset clears all valid flags and format_mode to BC1.
// The receiver cannot stall; each row strobe lasts one cycle.
`default_nettype none

module bc1_bc3_texture_block_decoder_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  bc13_pkg::in_t  item_i,
  input  logic           cfg_we_i,
  input  logic           cfg_wdata_i,
  output logic           res_strobe_o,
  output bc13_pkg::out_t res_o
);

  logic           mode_q;
  logic           in_vld_q, in_vld_d;
  bc13_pkg::in_t  in_q;
  logic           in_mode_q;
  logic           pal_vld_q, pal_vld_d;
  logic [1:0]     row_q, row_d;
  bc13_pkg::pal_t pal_q, pal_d;
  logic           strobe_q;
  bc13_pkg::out_t res_q, res_d;
  logic           pal_free, pal_load, accept;

  // Palette stage frees up as it emits its last row
  assign pal_free = !pal_vld_q || (row_q == 2'd3);
  assign pal_load = in_vld_q && pal_free;
  assign busy     = in_vld_q && !pal_free;
  assign accept   = start && !busy;

  bc13_palette u_palette (
    .blk_i (in_q),
    .bc3_i (in_mode_q),
    .pal_o (pal_d)
  );

  bc13_row_mux u_row_mux (
    .pal_i (pal_q),
    .row_i (row_q),
    .row_o (res_d)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (pal_load) begin
      in_vld_d = 1'b0;
    end

    pal_vld_d = pal_vld_q;
    row_d     = row_q;
    if (pal_load) begin
      pal_vld_d = 1'b1;
      row_d     = 2'd0;
    end else if (pal_vld_q) begin
      pal_vld_d = (row_q != 2'd3);
      row_d     = row_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= 1'b0;
      in_vld_q  <= 1'b0;
      pal_vld_q <= 1'b0;
      row_q     <= 2'd0;
      strobe_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      in_vld_q  <= in_vld_d;
      pal_vld_q <= pal_vld_d;
      row_q     <= row_d;
      strobe_q  <= pal_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q      <= item_i;
      in_mode_q <= mode_q;
    end
    if (pal_load) begin
      pal_q <= pal_d;
    end
    res_q <= res_d;
  end

  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

endmodule

`default_nettype wire

// ===== sv/bc13_checker.sv =====
// Port-level checks for the BC1/BC3 decoder, bound to the top level.
`default_nettype none

module bc13_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           res_strobe_o,
  input bc13_pkg::out_t res_o
);

  // Rows of a block come out in order with no gaps
  a_row_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && (res_o.row_number != 2'd3) |=>
      res_strobe_o && (res_o.row_number == 2'($past(res_o.row_number) + 2'd1)))
    else $error("row sequence broken");

  a_first_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_strobe_o) |-> (res_o.row_number == 2'd0))
    else $error("burst does not start at row 0");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> (res_o.last_row == (res_o.row_number == 2'd3)))
    else $error("last_row mismatch");

  // Busy only while a block is emitting rows
  a_busy_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> res_strobe_o)
    else $error("busy without pending rows");

endmodule

bind bc1_bc3_texture_block_decoder_top bc13_checker u_bc13_checker (.*);

`default_nettype wire
